// File: rtl/iowd_pkg.sv
// Shared constants for the IO output watchdog: time width, command codes and register indexes.
package iowd_pkg;

  localparam int TIME_BITS = 32;
  localparam int NOW_BITS = 32;
  localparam int TIMEOUT_BITS = 16;
  localparam int CMD_BITS = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int IN_TDATA_BITS = 40;
  localparam int OUT_TDATA_BITS = 8;

  localparam logic [TIME_BITS-1:0] SAMPLE_INTERVAL_MS = TIME_BITS'(20);
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(1000);

  localparam logic [CMD_BITS-1:0] CMD_NONE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_FEED = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_EXPIRE = 2'd2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MANAGE_FLEX = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MANAGE_HIGH_CURRENT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MANAGE_COMM = 3'd4;

endpackage

// File: rtl/io_output_watchdog_top.sv
// IO output watchdog top level: beat register, watchdog update logic and result register.
// Each accepted beat goes through the beat register and then the result register; the state
// update is one pass of compare and add logic, one beat per cycle unless the output stalls.
// Reset is synchronous and returns all watchdog state and the configuration to defaults.
// After reset the block accepts beats in the next cycle; no clearing pass is needed.
module io_output_watchdog_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // now_ms [31:0], command [33:32], gpio_is_output [34], zero fill [39:35]
  input  logic [iowd_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  // op [0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // expired [0], outputs_suspended [1], flex_suspended [2], high_current_off [3],
  // comm_off [4], gpio_out_flag [5], zero fill [7:6]
  output logic [iowd_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [iowd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [iowd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic                                watchdog_enable;
  logic [iowd_pkg::TIMEOUT_BITS-1:0]   timeout_ms;
  logic                                manage_flex;
  logic                                manage_high_current;
  logic                                manage_comm;

  logic                                in_valid;
  logic                                in_op;
  logic [iowd_pkg::NOW_BITS-1:0]       in_now;
  logic [iowd_pkg::CMD_BITS-1:0]       in_command;
  logic                                in_gpio;

  logic [iowd_pkg::TIME_BITS-1:0]      last_sample_time;
  logic [iowd_pkg::TIME_BITS-1:0]      fed_time;
  logic                                prev_enable;
  logic [iowd_pkg::CMD_BITS-1:0]       pending_command;
  logic                                expired_flag;
  logic                                suspend_all;
  logic                                suspend_flex;
  logic                                suspend_high_current;
  logic                                suspend_comm;
  logic                                sampled_gpio_out;

  logic [iowd_pkg::TIME_BITS-1:0]      last_sample_time_next;
  logic [iowd_pkg::TIME_BITS-1:0]      fed_time_next;
  logic [iowd_pkg::CMD_BITS-1:0]       pending_command_next;
  logic                                expired_flag_next;
  logic                                suspend_all_next;
  logic                                suspend_flex_next;
  logic                                suspend_high_current_next;
  logic                                suspend_comm_next;
  logic                                sampled_gpio_out_next;

  logic                                advance;
  logic [iowd_pkg::TIME_BITS-1:0]      now;
  logic [iowd_pkg::TIME_BITS-1:0]      timeout_ext;
  logic [iowd_pkg::TIME_BITS-1:0]      sample_diff;
  logic [iowd_pkg::TIME_BITS-1:0]      fed_diff;
  logic [iowd_pkg::TIME_BITS-1:0]      expire_diff;
  logic                                restart;
  logic                                reach_keep;
  logic                                reach_restart;
  logic                                reach_expire;
  logic                                reach;

  assign advance = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      watchdog_enable <= 1'b0;
      timeout_ms <= iowd_pkg::TIMEOUT_RESET;
      manage_flex <= 1'b1;
      manage_high_current <= 1'b1;
      manage_comm <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        iowd_pkg::REG_ENABLE: watchdog_enable <= cfg_data[0];
        iowd_pkg::REG_TIMEOUT: timeout_ms <= cfg_data[iowd_pkg::TIMEOUT_BITS-1:0];
        iowd_pkg::REG_MANAGE_FLEX: manage_flex <= cfg_data[0];
        iowd_pkg::REG_MANAGE_HIGH_CURRENT: manage_high_current <= cfg_data[0];
        iowd_pkg::REG_MANAGE_COMM: manage_comm <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op <= s_axis_tuser;
      in_now <= s_axis_tdata[iowd_pkg::NOW_BITS-1:0];
      in_command <= s_axis_tdata[iowd_pkg::NOW_BITS +: iowd_pkg::CMD_BITS];
      in_gpio <= s_axis_tdata[iowd_pkg::NOW_BITS + iowd_pkg::CMD_BITS];
    end
  end

  assign now = iowd_pkg::TIME_BITS'(in_now);
  assign timeout_ext = iowd_pkg::TIME_BITS'(timeout_ms);
  assign sample_diff = now - last_sample_time;
  assign fed_diff = now - fed_time;
  assign expire_diff = '0 - timeout_ext;
  assign restart = (pending_command == iowd_pkg::CMD_FEED) || !prev_enable;
  assign reach_keep = fed_diff >= timeout_ext;
  assign reach_restart = timeout_ms == '0;
  assign reach_expire = expire_diff >= timeout_ext;
  assign reach = restart ? reach_restart :
                 (pending_command == iowd_pkg::CMD_EXPIRE) ? reach_expire : reach_keep;

  always_comb begin
    last_sample_time_next = last_sample_time;
    fed_time_next = fed_time;
    pending_command_next = pending_command;
    expired_flag_next = expired_flag;
    suspend_all_next = suspend_all;
    suspend_flex_next = suspend_flex;
    suspend_high_current_next = suspend_high_current;
    suspend_comm_next = suspend_comm;
    sampled_gpio_out_next = sampled_gpio_out;
    if (in_op == iowd_pkg::OP_COMMAND) begin
      pending_command_next = in_command;
    end else begin
      if (now < last_sample_time) begin
        last_sample_time_next = now;
      end else if (sample_diff >= iowd_pkg::SAMPLE_INTERVAL_MS) begin
        last_sample_time_next = now;
        sampled_gpio_out_next = in_gpio;
      end
      if (watchdog_enable) begin
        if (!expired_flag) begin
          if (restart) begin
            fed_time_next = now;
            pending_command_next = iowd_pkg::CMD_NONE;
          end else if (pending_command == iowd_pkg::CMD_EXPIRE) begin
            fed_time_next = now + timeout_ext;
            pending_command_next = iowd_pkg::CMD_NONE;
          end
          if (reach) begin
            if (!suspend_all) begin
              if (manage_flex) begin
                suspend_flex_next = 1'b1;
              end
              if (in_gpio && manage_high_current) begin
                suspend_high_current_next = 1'b1;
              end
              if (manage_comm) begin
                suspend_comm_next = 1'b1;
              end
              suspend_all_next = 1'b1;
            end
            expired_flag_next = 1'b1;
          end
        end else if (restart) begin
          fed_time_next = now;
          pending_command_next = iowd_pkg::CMD_NONE;
          suspend_all_next = 1'b0;
          suspend_flex_next = 1'b0;
          suspend_high_current_next = 1'b0;
          suspend_comm_next = 1'b0;
          expired_flag_next = 1'b0;
        end
      end else if (expired_flag) begin
        suspend_all_next = 1'b0;
        suspend_flex_next = 1'b0;
        suspend_high_current_next = 1'b0;
        suspend_comm_next = 1'b0;
        expired_flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time <= '0;
      fed_time <= '0;
      prev_enable <= 1'b0;
      pending_command <= iowd_pkg::CMD_NONE;
      expired_flag <= 1'b0;
      suspend_all <= 1'b0;
      suspend_flex <= 1'b0;
      suspend_high_current <= 1'b0;
      suspend_comm <= 1'b0;
      sampled_gpio_out <= 1'b0;
    end else if (advance) begin
      last_sample_time <= last_sample_time_next;
      fed_time <= fed_time_next;
      pending_command <= pending_command_next;
      expired_flag <= expired_flag_next;
      suspend_all <= suspend_all_next;
      suspend_flex <= suspend_flex_next;
      suspend_high_current <= suspend_high_current_next;
      suspend_comm <= suspend_comm_next;
      sampled_gpio_out <= sampled_gpio_out_next;
      if (in_op == iowd_pkg::OP_TICK) begin
        prev_enable <= watchdog_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {2'b00, sampled_gpio_out_next, suspend_comm_next,
                       suspend_high_current_next, suspend_flex_next,
                       suspend_all_next, expired_flag_next};
    end
  end

  assert property (@(posedge clk) disable iff (rst) suspend_all == expired_flag)
    else $error("Suspend state and expired state disagree.");

  assert property (@(posedge clk) disable iff (rst)
    (suspend_flex || suspend_high_current || suspend_comm) |-> suspend_all)
    else $error("An output group is suspended without the watchdog holding outputs.");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_axis_tvalid && !m_axis_tready) |=> (in_valid && $stable(fed_time)))
    else $error("A stalled input beat was dropped or changed the watchdog state.");

endmodule

// File: bench/tb.sv
// Self-checking bench for the IO output watchdog: directed table, random phases, stream checks.
module tb;
  import iowd_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1350;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // now_ms [31:0], command [33:32], gpio_is_output [34], zero fill [39:35]
  logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
  // op [0]
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // expired [0], outputs_suspended [1], flex_suspended [2], high_current_off [3],
  // comm_off [4], gpio_out_flag [5], zero fill [7:6]
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  io_output_watchdog_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  typedef struct packed {
    logic                      is_reg;
    logic [CFG_INDEX_BITS-1:0] reg_index;
    logic [CFG_DATA_BITS-1:0]  reg_value;
    logic                      op;
    logic [NOW_BITS-1:0]       now;
    logic [CMD_BITS-1:0]       cmd;
    logic                      gpio;
    logic                      typed;
    logic [5:0]                status;
  } plan_row_t;

  // Watchdog configuration and state as the bench expects them.
  logic                    wd_enable;
  logic [TIMEOUT_BITS-1:0] wd_timeout;
  logic                    wd_manage_flex;
  logic                    wd_manage_hc;
  logic                    wd_manage_comm;
  logic [TIME_BITS-1:0]    wd_last_sample;
  logic [TIME_BITS-1:0]    wd_fed;
  logic                    wd_prev_en;
  logic [CMD_BITS-1:0]     wd_pending;
  logic                    wd_expired;
  logic                    wd_hold_all;
  logic                    wd_hold_flex;
  logic                    wd_hold_hc;
  logic                    wd_hold_comm;
  logic                    wd_gpio_flag;

  logic [5:0] status_q[$];
  plan_row_t  plan_q[$];
  string      status_field [6] = '{"expired", "outputs_suspended", "flex_suspended",
                                   "high_current_off", "comm_off", "gpio_out_flag"};
  int         errors = 0;
  int         burst_left = 0;
  int         stall_cycles = 0;
  int         rx_left = 0;
  int         rx_mode = 0;
  logic [5:0] got_status;
  logic [5:0] want_status;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [5:0] predict_status(input logic op, input logic [NOW_BITS-1:0] now,
                                                input logic [CMD_BITS-1:0] cmd, input logic gpio);
    logic [TIME_BITS-1:0] span;
    span = TIME_BITS'(wd_timeout);
    if (op == OP_COMMAND) begin
      wd_pending = cmd;
    end else begin
      if (now < wd_last_sample) begin
        wd_last_sample = now;
      end else if (now - wd_last_sample >= SAMPLE_INTERVAL_MS) begin
        wd_last_sample = now;
        wd_gpio_flag = gpio;
      end
      if (wd_enable) begin
        if (!wd_expired) begin
          if (wd_pending == CMD_FEED || !wd_prev_en) begin
            wd_fed = now;
            wd_pending = CMD_NONE;
          end else if (wd_pending == CMD_EXPIRE) begin
            wd_fed = now + span;
            wd_pending = CMD_NONE;
          end
          if (now - wd_fed >= span) begin
            if (!wd_hold_all) begin
              if (wd_manage_flex) wd_hold_flex = 1'b1;
              if (gpio && wd_manage_hc) wd_hold_hc = 1'b1;
              if (wd_manage_comm) wd_hold_comm = 1'b1;
              wd_hold_all = 1'b1;
            end
            wd_expired = 1'b1;
          end
        end else if (wd_pending == CMD_FEED || !wd_prev_en) begin
          wd_fed = now;
          wd_pending = CMD_NONE;
          {wd_hold_all, wd_hold_flex, wd_hold_hc, wd_hold_comm} = 4'b0000;
          wd_expired = 1'b0;
        end
      end else if (wd_expired) begin
        {wd_hold_all, wd_hold_flex, wd_hold_hc, wd_hold_comm} = 4'b0000;
        wd_expired = 1'b0;
      end
      wd_prev_en = wd_enable;
    end
    return {wd_gpio_flag, wd_hold_comm, wd_hold_hc, wd_hold_flex, wd_hold_all, wd_expired};
  endfunction

  function automatic plan_row_t item_row(input logic op, input logic [NOW_BITS-1:0] now,
                                         input logic [CMD_BITS-1:0] cmd, input logic gpio,
                                         input logic typed, input logic [5:0] status);
    plan_row_t row;
    row = '0;
    row.op = op;
    row.now = now;
    row.cmd = cmd;
    row.gpio = gpio;
    row.typed = typed;
    row.status = status;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_INDEX_BITS-1:0] index,
                                        input logic [CFG_DATA_BITS-1:0] value);
    plan_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_index = index;
    row.reg_value = value;
    return row;
  endfunction

  task automatic send_item(input logic op, input logic [NOW_BITS-1:0] now,
                           input logic [CMD_BITS-1:0] cmd, input logic gpio,
                           input logic typed, input logic [5:0] status);
    int gap;
    logic [5:0] predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {5'd0, gpio, cmd, now};
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_status(op, now, cmd, gpio);
    status_q.push_back(typed ? status : predicted);
  endtask

  // Registers change only with the block idle, so the sender holds off until the results drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_ENABLE:              wd_enable = value[0];
      REG_TIMEOUT:             wd_timeout = value;
      REG_MANAGE_FLEX:         wd_manage_flex = value[0];
      REG_MANAGE_HIGH_CURRENT: wd_manage_hc = value[0];
      REG_MANAGE_COMM:         wd_manage_comm = value[0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] flag_value(input logic flag);
    return {($urandom_range(0, 1) == 0) ? 15'd0 : 15'($urandom), flag};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_left <= 0;
      rx_mode <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = m_axis_tdata[5:0];
        if (status_q.size() == 0) begin
          $display("%0t: result beat %b arrived with nothing expected", $time, got_status);
          errors++;
        end else begin
          want_status = status_q.pop_front();
          for (int b = 0; b < 6; b++) begin
            if (got_status[b] !== want_status[b]) begin
              $display("%0t: %s expected %b actual %b", $time, status_field[b],
                       want_status[b], got_status[b]);
              errors++;
            end
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_left <= $urandom_range(20, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_left[1:0] != 2'd0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [NOW_BITS-1:0] clock_ms;
    logic [NOW_BITS-1:0] now;
    logic [CMD_BITS-1:0] cmd;
    logic                op;
    logic [CFG_DATA_BITS-1:0] timeout;
    int sent;
    int count;
    int pick;

    wd_enable = 1'b0;
    wd_timeout = TIMEOUT_RESET;
    wd_manage_flex = 1'b1;
    wd_manage_hc = 1'b1;
    wd_manage_comm = 1'b1;
    wd_last_sample = '0;
    wd_fed = '0;
    wd_prev_en = 1'b0;
    wd_pending = CMD_NONE;
    wd_expired = 1'b0;
    {wd_hold_all, wd_hold_flex, wd_hold_hc, wd_hold_comm} = 4'b0000;
    wd_gpio_flag = 1'b0;

    plan_q.push_back(item_row(OP_TICK, 32'd0, CMD_NONE, 1'b1, 1'b1, 6'b000000));
    plan_q.push_back(item_row(OP_TICK, 32'd20, CMD_NONE, 1'b1, 1'b1, 6'b100000));
    plan_q.push_back(reg_row(REG_ENABLE, 16'd1));
    plan_q.push_back(reg_row(REG_TIMEOUT, 16'd0));
    plan_q.push_back(item_row(OP_TICK, 32'd25, CMD_NONE, 1'b1, 1'b1, 6'b111111));
    plan_q.push_back(item_row(OP_COMMAND, 32'hFFFF_FFFF, CMD_FEED, 1'b0, 1'b1, 6'b111111));
    plan_q.push_back(item_row(OP_TICK, 32'd30, CMD_NONE, 1'b0, 1'b1, 6'b100000));
    plan_q.push_back(item_row(OP_TICK, 32'd31, CMD_NONE, 1'b0, 1'b1, 6'b110111));
    plan_q.push_back(reg_row(REG_TIMEOUT, 16'hFFFF));
    plan_q.push_back(reg_row(REG_ENABLE, 16'd0));
    plan_q.push_back(item_row(OP_TICK, 32'd32, CMD_NONE, 1'b1, 1'b1, 6'b100000));
    plan_q.push_back(reg_row(REG_ENABLE, 16'd1));
    plan_q.push_back(item_row(OP_COMMAND, 32'd0, CMD_EXPIRE, 1'b1, 1'b1, 6'b100000));
    plan_q.push_back(item_row(OP_TICK, 32'hFFFF_FFFF, CMD_SPARE, 1'b0, 1'b0, 6'b000000));
    plan_q.push_back(item_row(OP_COMMAND, 32'd0, CMD_EXPIRE, 1'b0, 1'b0, 6'b000000));
    plan_q.push_back(item_row(OP_TICK, 32'd0, CMD_NONE, 1'b1, 1'b0, 6'b000000));
    plan_q.push_back(item_row(OP_COMMAND, 32'd0, CMD_EXPIRE, 1'b0, 1'b0, 6'b000000));
    plan_q.push_back(item_row(OP_TICK, 32'd5, CMD_NONE, 1'b1, 1'b0, 6'b000000));
    plan_q.push_back(item_row(OP_COMMAND, 32'd0, CMD_SPARE, 1'b0, 1'b0, 6'b000000));
    plan_q.push_back(item_row(OP_TICK, 32'd40, CMD_NONE, 1'b1, 1'b0, 6'b000000));
    plan_q.push_back(item_row(OP_COMMAND, 32'd0, CMD_NONE, 1'b0, 1'b0, 6'b000000));
    plan_q.push_back(reg_row(REG_TIMEOUT, 16'd1));
    plan_q.push_back(reg_row(REG_MANAGE_FLEX, 16'd0));
    plan_q.push_back(reg_row(REG_MANAGE_HIGH_CURRENT, 16'd0));
    plan_q.push_back(reg_row(REG_MANAGE_COMM, 16'd0));
    plan_q.push_back(item_row(OP_COMMAND, 32'd0, CMD_FEED, 1'b0, 1'b0, 6'b000000));
    plan_q.push_back(item_row(OP_TICK, 32'd100, CMD_NONE, 1'b1, 1'b0, 6'b000000));
    plan_q.push_back(item_row(OP_TICK, 32'd101, CMD_NONE, 1'b1, 1'b0, 6'b000000));
    plan_q.push_back(reg_row(REG_ENABLE, 16'd0));
    plan_q.push_back(item_row(OP_TICK, 32'd102, CMD_NONE, 1'b0, 1'b0, 6'b000000));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_q[i]) begin
      if (plan_q[i].is_reg) begin
        if (i == 0 || !plan_q[i-1].is_reg) settle();
        write_reg(plan_q[i].reg_index, plan_q[i].reg_value);
      end else begin
        if (i != 0 && plan_q[i-1].is_reg) cfg_valid <= 1'b0;
        send_item(plan_q[i].op, plan_q[i].now, plan_q[i].cmd, plan_q[i].gpio,
                  plan_q[i].typed, plan_q[i].status);
      end
    end

    clock_ms = 32'd200;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 9);
      if (pick == 0) timeout = 16'd0;
      else if (pick == 1) timeout = 16'hFFFF;
      else if (pick == 2) timeout = 16'($urandom);
      else timeout = 16'($urandom_range(1, 60));
      if ($urandom_range(0, 5) == 0) write_reg(3'($urandom_range(5, 7)), 16'($urandom));
      write_reg(REG_ENABLE, flag_value($urandom_range(0, 4) != 0));
      write_reg(REG_TIMEOUT, timeout);
      write_reg(REG_MANAGE_FLEX, flag_value(1'($urandom_range(0, 1))));
      write_reg(REG_MANAGE_HIGH_CURRENT, flag_value(1'($urandom_range(0, 1))));
      write_reg(REG_MANAGE_COMM, flag_value(1'($urandom_range(0, 1))));
      cfg_valid <= 1'b0;
      count = $urandom_range(60, 140);
      for (int k = 0; k < count; k++) begin
        op = ($urandom_range(0, 4) == 0) ? OP_COMMAND : OP_TICK;
        pick = $urandom_range(0, 9);
        if (pick < 5) cmd = CMD_FEED;
        else if (pick < 7) cmd = CMD_EXPIRE;
        else if (pick < 9) cmd = CMD_NONE;
        else cmd = CMD_SPARE;
        if (op == OP_TICK) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) clock_ms = clock_ms + $urandom_range(0, 8);
          else if (pick < 88) clock_ms = clock_ms + $urandom_range(9, 40);
          else if (pick < 94) clock_ms = clock_ms + $urandom_range(0, 2 * timeout + 2);
          else if (pick < 97) clock_ms = $urandom;
          else clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 50);
          now = clock_ms;
        end else begin
          now = $urandom;
        end
        send_item(op, now, cmd, 1'($urandom_range(0, 1)), 1'b0, 6'b000000);
      end
      sent += count;
    end

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
